// ----- hdl/cpt_pkg.sv -----
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types and constants of the calibrated proximity trigger.
// ----------------------------------------------------------------------------
package cpt_pkg;

	// input transaction kinds, carried in s_tuser
	typedef enum logic [1:0] {
		KIND_SAMPLE    = 2'd0,
		KIND_TICK      = 2'd1,
		KIND_CALIBRATE = 2'd2
	} kind_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_WINDOW_MS     = 3'd0,
		CFG_SPREAD_GAIN   = 3'd1,
		CFG_SPREAD_OFFSET = 3'd2,
		CFG_ENABLED       = 3'd3,
		CFG_HOLDOFF_MS    = 3'd4,
		CFG_KEEPALIVE_MS  = 3'd5
	} cfg_index_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 22;
	localparam int WINDOW_W    = 16;
	localparam int GAIN_W      = 8;
	localparam int HOLDOFF_W   = 16;
	localparam int SINCE_W     = 22;
	localparam int TOTAL_W     = 32;
	localparam int SPREAD_W    = 15;

	localparam logic [WINDOW_W-1:0]  WINDOW_MS_RST     = 16'd10000;
	localparam logic [GAIN_W-1:0]    SPREAD_GAIN_RST   = 8'd1;
	localparam logic [GAIN_W-1:0]    SPREAD_OFFSET_RST = 8'd1;
	localparam logic                 ENABLED_RST       = 1'b1;
	localparam logic [HOLDOFF_W-1:0] HOLDOFF_MS_RST    = 16'd1000;
	localparam logic [SINCE_W-1:0]   KEEPALIVE_MS_RST  = 22'd1500000;
	localparam logic [SINCE_W-1:0]   SINCE_MAX         = 22'h3FFFFF;

	// one result, flash in the lowest bit
	typedef struct packed {
		logic [SPREAD_W-1:0] spread_b;
		logic [SPREAD_W-1:0] spread_a;
		logic                calibration_done;
		logic                calibrating;
		logic [TOTAL_W-1:0]  flash_total;
		logic                flash;
	} result_t;

	localparam int RESULT_W    = $bits(result_t);
	localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

	// bit positions of the result fields in m_tdata
	localparam int POS_FLASH       = 0;
	localparam int POS_TOTAL       = 1;
	localparam int POS_CALIBRATING = POS_TOTAL + TOTAL_W;
	localparam int POS_DONE        = POS_CALIBRATING + 1;

endpackage

// ----- hdl/cpt_threshold.sv -----
// ----------------------------------------------------------------------------
// cpt_threshold
// Threshold of one sensor: low - (spread * gain + offset), signed and wide.
// ----------------------------------------------------------------------------
module cpt_threshold #(
	parameter int DIST_W = 15
) (
	input  logic [DIST_W-1:0]          low,
	input  logic [DIST_W-1:0]          high,
	input  logic [cpt_pkg::GAIN_W-1:0] gain,
	input  logic [cpt_pkg::GAIN_W-1:0] offset,
	output logic [DIST_W-1:0]          limit,
	output logic                       negative
);

	localparam int PROD_W = DIST_W + cpt_pkg::GAIN_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int DIFF_W = SUM_W + 1;

	logic [DIST_W-1:0] spread;
	logic [PROD_W-1:0] product;
	logic [SUM_W-1:0]  margin;
	logic [DIFF_W-1:0] diff;

	always_comb begin
		spread   = high - low;
		product  = PROD_W'(spread) * PROD_W'(gain);
		margin   = SUM_W'(product) + SUM_W'(offset);
		diff     = DIFF_W'(low) - DIFF_W'(margin);
		negative = diff[DIFF_W-1];
		limit    = diff[DIST_W-1:0];
	end

endmodule

// ----- hdl/calibrated_proximity_trigger_unit.sv -----
// ----------------------------------------------------------------------------
// calibrated_proximity_trigger_unit
// Two-sensor proximity trigger with self calibration and keepalive flash.
// ----------------------------------------------------------------------------
// Each input transaction is a distance sample pair, a one millisecond tick
// or a calibration start, and yields exactly one result transaction. The
// block takes one transaction per clock cycle while the output is not
// stalled; a result passes the input register, then the result register, and
// the rate is set by the single-pass update of the calibration and flash
// state between them. s_tready follows m_tready combinationally, so a
// stalled output holds back the input only once both registers are full.
// A calibration window runs after reset. Configuration writes are always
// accepted (cfg_ready is tied high) and take effect on the next cycle; they
// are meant to be issued while no transaction is in flight.
// ----------------------------------------------------------------------------
module calibrated_proximity_trigger_unit #(
	parameter  int DISTANCE_BITS = 15,
	localparam int IN_TDATA_W    = ((2 * DISTANCE_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [IN_TDATA_W-1:0]             s_tdata,  // distance_a, distance_b, zero pad
	input  logic [1:0]                        s_tuser,  // kind
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [cpt_pkg::OUT_TDATA_W-1:0]   m_tdata,  // flash, flash_total, calibrating,
	                                                    // calibration_done, spread_a,
	                                                    // spread_b, zero pad
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cpt_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [cpt_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int DW         = DISTANCE_BITS;
	localparam int SPREAD_EXT = (DW > cpt_pkg::SPREAD_W) ? DW : cpt_pkg::SPREAD_W;
	localparam int PAD_W      = cpt_pkg::OUT_TDATA_W - cpt_pkg::RESULT_W;

	// configuration registers
	logic [cpt_pkg::WINDOW_W-1:0]  window_ms_q;
	logic [cpt_pkg::GAIN_W-1:0]    spread_gain_q;
	logic [cpt_pkg::GAIN_W-1:0]    spread_offset_q;
	logic                          enabled_q;
	logic [cpt_pkg::HOLDOFF_W-1:0] holdoff_ms_q;
	logic [cpt_pkg::SINCE_W-1:0]   keepalive_ms_q;

	// input stage
	logic          valid_s1;
	logic [1:0]    kind_s1;
	logic [DW-1:0] dist_a_s1;
	logic [DW-1:0] dist_b_s1;

	// result register
	logic                 out_valid_q;
	cpt_pkg::result_t     result_q;

	// calibration and flash state
	logic                          in_window_q;
	logic                          seen_q;
	logic [cpt_pkg::WINDOW_W-1:0]  elapsed_q;
	logic [DW-1:0]                 low_a_q, high_a_q, low_b_q, high_b_q;
	logic [DW-1:0]                 limit_a_q, limit_b_q;
	logic [cpt_pkg::SINCE_W-1:0]   since_q;
	logic [cpt_pkg::TOTAL_W-1:0]   counter_q;

	// next state
	logic                          in_window_d;
	logic                          seen_d;
	logic [cpt_pkg::WINDOW_W-1:0]  elapsed_d;
	logic [DW-1:0]                 low_a_d, high_a_d, low_b_d, high_b_d;
	logic [DW-1:0]                 limit_a_d, limit_b_d;
	logic [cpt_pkg::SINCE_W-1:0]   since_d;
	logic [cpt_pkg::TOTAL_W-1:0]   counter_d;
	logic                          flash_d;
	logic                          done_d;
	logic [DW-1:0]                 spread_a_d, spread_b_d;
	logic [SPREAD_EXT-1:0]         spread_a_ext, spread_b_ext;
	cpt_pkg::result_t              result_d;

	// candidate thresholds from the current window
	logic [DW-1:0] thr_a, thr_b;
	logic          neg_a, neg_b;

	logic advance;   // the result register can take a new result
	logic step;      // the item in the input stage is processed this cycle

	assign advance   = !out_valid_q || m_tready;
	assign step      = valid_s1 && advance;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {{PAD_W{1'b0}}, result_q};

	cpt_threshold #(
		.DIST_W (DW)
	) u_thr_a (
		.low      (low_a_q),
		.high     (high_a_q),
		.gain     (spread_gain_q),
		.offset   (spread_offset_q),
		.limit    (thr_a),
		.negative (neg_a)
	);

	cpt_threshold #(
		.DIST_W (DW)
	) u_thr_b (
		.low      (low_b_q),
		.high     (high_b_q),
		.gain     (spread_gain_q),
		.offset   (spread_offset_q),
		.limit    (thr_b),
		.negative (neg_b)
	);

	// configuration writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_ms_q     <= cpt_pkg::WINDOW_MS_RST;
			spread_gain_q   <= cpt_pkg::SPREAD_GAIN_RST;
			spread_offset_q <= cpt_pkg::SPREAD_OFFSET_RST;
			enabled_q       <= cpt_pkg::ENABLED_RST;
			holdoff_ms_q    <= cpt_pkg::HOLDOFF_MS_RST;
			keepalive_ms_q  <= cpt_pkg::KEEPALIVE_MS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				cpt_pkg::CFG_WINDOW_MS:     window_ms_q     <= cfg_data[cpt_pkg::WINDOW_W-1:0];
				cpt_pkg::CFG_SPREAD_GAIN:   spread_gain_q   <= cfg_data[cpt_pkg::GAIN_W-1:0];
				cpt_pkg::CFG_SPREAD_OFFSET: spread_offset_q <= cfg_data[cpt_pkg::GAIN_W-1:0];
				cpt_pkg::CFG_ENABLED:       enabled_q       <= cfg_data[0];
				cpt_pkg::CFG_HOLDOFF_MS:    holdoff_ms_q    <= cfg_data[cpt_pkg::HOLDOFF_W-1:0];
				cpt_pkg::CFG_KEEPALIVE_MS:  keepalive_ms_q  <= cfg_data[cpt_pkg::SINCE_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage: capture a transaction whenever the stage is free or drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1   <= s_tuser;
			dist_a_s1 <= s_tdata[DW-1:0];
			dist_b_s1 <= s_tdata[2*DW-1:DW];
		end
	end

	// single-pass update of the trigger state for the item in the input stage
	always_comb begin
		in_window_d = in_window_q;
		seen_d      = seen_q;
		elapsed_d   = elapsed_q;
		low_a_d     = low_a_q;
		high_a_d    = high_a_q;
		low_b_d     = low_b_q;
		high_b_d    = high_b_q;
		limit_a_d   = limit_a_q;
		limit_b_d   = limit_b_q;
		since_d     = since_q;
		counter_d   = counter_q;
		flash_d     = 1'b0;
		done_d      = 1'b0;

		case (kind_s1)
			cpt_pkg::KIND_SAMPLE: begin
				if (in_window_q) begin
					// track min and max, the first sample seeds both
					if (!seen_q) begin
						low_a_d  = dist_a_s1;
						high_a_d = dist_a_s1;
						low_b_d  = dist_b_s1;
						high_b_d = dist_b_s1;
						seen_d   = 1'b1;
					end else begin
						if (dist_a_s1 < low_a_q)  low_a_d  = dist_a_s1;
						if (dist_a_s1 > high_a_q) high_a_d = dist_a_s1;
						if (dist_b_s1 < low_b_q)  low_b_d  = dist_b_s1;
						if (dist_b_s1 > high_b_q) high_b_d = dist_b_s1;
					end
				end else if (enabled_q
				             && (dist_a_s1 <= limit_a_q || dist_b_s1 <= limit_b_q)
				             && since_q >= cpt_pkg::SINCE_W'(holdoff_ms_q)) begin
					flash_d   = 1'b1;
					since_d   = '0;
					counter_d = counter_q + 32'd1;
				end
			end
			cpt_pkg::KIND_TICK: begin
				// saturating time since the last flash
				if (since_q != cpt_pkg::SINCE_MAX) since_d = since_q + 22'd1;
				if (in_window_q) begin
					if (elapsed_q >= window_ms_q) begin
						// window over: accept the thresholds or start again
						if (!seen_q) begin
							elapsed_d = '0;
						end else if (neg_a || neg_b) begin
							seen_d    = 1'b0;
							elapsed_d = '0;
						end else begin
							limit_a_d   = thr_a;
							limit_b_d   = thr_b;
							in_window_d = 1'b0;
							done_d      = 1'b1;
						end
					end else begin
						elapsed_d = elapsed_q + 16'd1;
					end
				end
				// keepalive, ignores enabled, never during a window
				if (!in_window_d && since_d > keepalive_ms_q) begin
					flash_d   = 1'b1;
					since_d   = '0;
					counter_d = counter_q + 32'd1;
				end
			end
			cpt_pkg::KIND_CALIBRATE: begin
				in_window_d = 1'b1;
				seen_d      = 1'b0;
				elapsed_d   = '0;
			end
			default: ;
		endcase

		spread_a_d   = high_a_d - low_a_d;
		spread_b_d   = high_b_d - low_b_d;
		spread_a_ext = SPREAD_EXT'(spread_a_d);
		spread_b_ext = SPREAD_EXT'(spread_b_d);

		result_d.flash            = flash_d;
		result_d.flash_total      = counter_d;
		result_d.calibrating      = in_window_d;
		result_d.calibration_done = done_d;
		result_d.spread_a         = spread_a_ext[cpt_pkg::SPREAD_W-1:0];
		result_d.spread_b         = spread_b_ext[cpt_pkg::SPREAD_W-1:0];
	end

	// state registers, updated once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_window_q <= 1'b1;
			seen_q      <= 1'b0;
			elapsed_q   <= '0;
			low_a_q     <= '0;
			high_a_q    <= '0;
			low_b_q     <= '0;
			high_b_q    <= '0;
			limit_a_q   <= '0;
			limit_b_q   <= '0;
			since_q     <= '0;
			counter_q   <= '0;
		end else if (step) begin
			in_window_q <= in_window_d;
			seen_q      <= seen_d;
			elapsed_q   <= elapsed_d;
			low_a_q     <= low_a_d;
			high_a_q    <= high_a_d;
			low_b_q     <= low_b_d;
			high_b_q    <= high_b_d;
			limit_a_q   <= limit_a_d;
			limit_b_q   <= limit_b_d;
			since_q     <= since_d;
			counter_q   <= counter_d;
		end
	end

	// result register: holds while the downstream stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result_d;
		end
	end

endmodule

// ----- hdl/cpt_checker.sv -----
// ----------------------------------------------------------------------------
// cpt_checker
// Port-level checks of the proximity trigger result stream.
// ----------------------------------------------------------------------------
module cpt_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [cpt_pkg::OUT_TDATA_W-1:0] m_tdata
);

	logic                        out_xfer;
	logic                        flash;
	logic                        calibrating;
	logic                        done;
	logic [cpt_pkg::TOTAL_W-1:0] total;
	logic [cpt_pkg::TOTAL_W-1:0] last_total_q;
	logic [cpt_pkg::TOTAL_W-1:0] expected_total;

	assign out_xfer       = m_tvalid && m_tready;
	assign flash          = m_tdata[cpt_pkg::POS_FLASH];
	assign calibrating    = m_tdata[cpt_pkg::POS_CALIBRATING];
	assign done           = m_tdata[cpt_pkg::POS_DONE];
	assign total          = m_tdata[cpt_pkg::POS_TOTAL +: cpt_pkg::TOTAL_W];
	assign expected_total = last_total_q + cpt_pkg::TOTAL_W'(flash);

	// flash count seen in the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_total_q <= '0;
		end else if (out_xfer) begin
			last_total_q <= total;
		end
	end

	a_total_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> total == expected_total)
		else $error("flash total does not follow the flash bits");

	a_no_flash_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && flash |-> !calibrating)
		else $error("flash during a calibration window");

	a_done_ends_window: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && done |-> !calibrating)
		else $error("calibration done while still calibrating");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result transaction withdrawn while stalled");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result transaction changed while stalled");

endmodule

bind calibrated_proximity_trigger_unit cpt_checker u_cpt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- dv/calibrated_proximity_trigger_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calibrated_proximity_trigger_unit_tb
// Self-checking bench for the two-sensor proximity trigger.
// ----------------------------------------------------------------------------
// A clocked driver feeds readings (sample pairs, millisecond ticks, calibration
// starts) from a queue that the main sequence fills. An in-bench trigger model
// predicts one result per accepted reading, and a clocked monitor compares each
// result transaction against the oldest prediction. Settings are reprogrammed
// between phases while nothing is in flight. Directed readings cover the
// distance extremes and the calibration corner cases. Random phases mostly run
// full calibrate-then-watch sequences, with some noise mixed in, under three
// flow-control mixes.
// ----------------------------------------------------------------------------
module calibrated_proximity_trigger_unit_tb;
	import cpt_pkg::*;

	localparam int DIST_W          = 15;
	localparam int IN_W            = ((2 * DIST_W + 7) / 8) * 8;
	localparam int QUIET_LIMIT     = 5000;
	localparam int PHASE_READINGS  = 195;
	localparam int RANDOM_PHASES   = 9;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// one input reading as the bench sees it; kind is left wide enough for
	// the unused code
	typedef struct {
		logic [1:0]        kind;
		logic [DIST_W-1:0] dist_a;
		logic [DIST_W-1:0] dist_b;
	} reading_t;

	typedef struct {
		logic [WINDOW_W-1:0]  window_ms;
		logic [GAIN_W-1:0]    gain;
		logic [GAIN_W-1:0]    offset;
		logic                 enabled;
		logic [HOLDOFF_W-1:0] holdoff_ms;
		logic [SINCE_W-1:0]   keepalive_ms;
	} trig_cfg_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	always #5 clk = ~clk;

	calibrated_proximity_trigger_unit #(
		.DISTANCE_BITS(DIST_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// bench bookkeeping
	reading_t readings_pending[$];
	result_t  results_due[$];
	reading_t reading_on_bus;
	bit       reading_taken = 1'b0;
	int       readings_queued = 0;
	int       readings_accepted = 0;
	int       unused_queued = 0;
	int       mismatches = 0;
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;
	int       quiet_cycles = 0;

	// trigger model: settings copy, reset values
	logic [WINDOW_W-1:0]  set_window    = WINDOW_MS_RST;
	logic [GAIN_W-1:0]    set_gain      = SPREAD_GAIN_RST;
	logic [GAIN_W-1:0]    set_offset    = SPREAD_OFFSET_RST;
	logic                 set_enabled   = ENABLED_RST;
	logic [HOLDOFF_W-1:0] set_holdoff   = HOLDOFF_MS_RST;
	logic [SINCE_W-1:0]   set_keepalive = KEEPALIVE_MS_RST;

	// trigger model: state, calibration window open after reset
	bit                 cal_open = 1'b1;
	bit                 cal_seen = 1'b0;
	bit [WINDOW_W-1:0]  cal_ticks = '0;
	bit [DIST_W-1:0]    min_a = '0, max_a = '0, min_b = '0, max_b = '0;
	bit [DIST_W-1:0]    trip_a = '0, trip_b = '0;
	bit [SINCE_W-1:0]   ticks_since_flash = '0;
	bit [TOTAL_W-1:0]   flashes_fired = '0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
	endtask

	function automatic void store_setting(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_WINDOW_MS:     set_window    = val[WINDOW_W-1:0];
			CFG_SPREAD_GAIN:   set_gain      = val[GAIN_W-1:0];
			CFG_SPREAD_OFFSET: set_offset    = val[GAIN_W-1:0];
			CFG_ENABLED:       set_enabled   = val[0];
			CFG_HOLDOFF_MS:    set_holdoff   = val[HOLDOFF_W-1:0];
			CFG_KEEPALIVE_MS:  set_keepalive = val[SINCE_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void open_window();
		cal_open  = 1'b1;
		cal_seen  = 1'b0;
		cal_ticks = '0;
	endfunction

	// end of a calibration window, returns 1 when the new thresholds are usable
	function automatic bit close_window();
		bit [DIST_W-1:0] spr_a, spr_b;
		longint thr_a, thr_b;
		if (!cal_seen) begin
			open_window();
			return 1'b0;
		end
		spr_a = max_a - min_a;
		spr_b = max_b - min_b;
		// computed 64 bits wide so a large gain cannot wrap
		thr_a = longint'(min_a) - (longint'(spr_a) * longint'(set_gain) + longint'(set_offset));
		thr_b = longint'(min_b) - (longint'(spr_b) * longint'(set_gain) + longint'(set_offset));
		if (thr_a < 0 || thr_b < 0) begin
			open_window();
			return 1'b0;
		end
		trip_a   = thr_a[DIST_W-1:0];
		trip_b   = thr_b[DIST_W-1:0];
		cal_open = 1'b0;
		return 1'b1;
	endfunction

	function automatic void fire_flash();
		ticks_since_flash = '0;
		flashes_fired     = flashes_fired + 1'b1;
	endfunction

	// advance the trigger model by one reading and queue the result it owes
	function automatic void predict_trigger(input reading_t r);
		result_t res;
		bit fired, done;
		fired = 1'b0;
		done  = 1'b0;
		case (r.kind)
			KIND_SAMPLE: begin
				if (cal_open) begin
					if (!cal_seen) begin
						min_a = r.dist_a; max_a = r.dist_a;
						min_b = r.dist_b; max_b = r.dist_b;
						cal_seen = 1'b1;
					end else begin
						if (r.dist_a < min_a) min_a = r.dist_a;
						if (r.dist_a > max_a) max_a = r.dist_a;
						if (r.dist_b < min_b) min_b = r.dist_b;
						if (r.dist_b > max_b) max_b = r.dist_b;
					end
				end else if (set_enabled && (r.dist_a <= trip_a || r.dist_b <= trip_b)
						&& ticks_since_flash >= set_holdoff) begin
					fire_flash();
					fired = 1'b1;
				end
			end
			KIND_TICK: begin
				if (ticks_since_flash != SINCE_MAX)
					ticks_since_flash++;
				if (cal_open) begin
					if (cal_ticks >= set_window)
						done = close_window();
					else
						cal_ticks++;
				end
				// a keepalive that fell due inside the window fires here
				if (!cal_open && ticks_since_flash > set_keepalive) begin
					fire_flash();
					fired = 1'b1;
				end
			end
			KIND_CALIBRATE: open_window();
			default: ;
		endcase
		res.flash            = fired;
		res.flash_total      = flashes_fired;
		res.calibrating      = cal_open;
		res.calibration_done = done;
		res.spread_a         = max_a - min_a;
		res.spread_b         = max_b - min_b;
		results_due.push_back(res);
	endfunction

	// driver: one transaction presented at a time, changed on the falling edge
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || reading_taken)) begin
			reading_taken = 1'b0;
			if (readings_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				reading_on_bus = readings_pending.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= reading_on_bus.kind;
				s_tdata  <= {{(IN_W - 2 * DIST_W){1'b0}}, reading_on_bus.dist_b,
					reading_on_bus.dist_a};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// monitor: input acceptance feeds the model, result acceptance is checked
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && s_tvalid && s_tready) begin
			predict_trigger(reading_on_bus);
			reading_taken = 1'b1;
			readings_accepted++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[RESULT_W-1:0]);
			if (results_due.size() == 0) begin
				report_mismatch("result without reading", m_tdata[63:0], '0);
			end else begin
				want = results_due.pop_front();
				if (got.flash !== want.flash)
					report_mismatch("flash", 64'(got.flash), 64'(want.flash));
				if (got.flash_total !== want.flash_total)
					report_mismatch("flash_total", 64'(got.flash_total),
						64'(want.flash_total));
				if (got.calibrating !== want.calibrating)
					report_mismatch("calibrating", 64'(got.calibrating),
						64'(want.calibrating));
				if (got.calibration_done !== want.calibration_done)
					report_mismatch("calibration_done", 64'(got.calibration_done),
						64'(want.calibration_done));
				if (got.spread_a !== want.spread_a)
					report_mismatch("spread_a", 64'(got.spread_a), 64'(want.spread_a));
				if (got.spread_b !== want.spread_b)
					report_mismatch("spread_b", 64'(got.spread_b), 64'(want.spread_b));
			end
		end
	end

	// watchdog: too long without any transaction means the block hung
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic push_reading(input logic [1:0] kind, input logic [DIST_W-1:0] da,
			input logic [DIST_W-1:0] db);
		reading_t r;
		r.kind   = kind;
		r.dist_a = da;
		r.dist_b = db;
		readings_pending.push_back(r);
		readings_queued++;
		if (kind == KIND_UNUSED)
			unused_queued++;
	endtask

	// all six registers in index order, valid held high across the burst
	task automatic program_trigger(input trig_cfg_t s);
		cfg_index_t idx;
		logic [CFG_DATA_W-1:0] val;
		idx = idx.first();
		forever begin
			case (idx)
				CFG_WINDOW_MS:     val = CFG_DATA_W'(s.window_ms);
				CFG_SPREAD_GAIN:   val = CFG_DATA_W'(s.gain);
				CFG_SPREAD_OFFSET: val = CFG_DATA_W'(s.offset);
				CFG_ENABLED:       val = CFG_DATA_W'(s.enabled);
				CFG_HOLDOFF_MS:    val = CFG_DATA_W'(s.holdoff_ms);
				default:           val = CFG_DATA_W'(s.keepalive_ms);
			endcase
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= val;
			do @(posedge clk); while (!cfg_ready);
			store_setting(idx, val);
			if (idx == idx.last())
				break;
			idx = idx.next();
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// every queued reading accepted and every result back, then a short pause
	// so the two pipeline stages are empty before the next setting change
	task automatic wait_settled();
		do @(negedge clk); while (readings_accepted != readings_queued || results_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [DIST_W-1:0] clip_distance(input int v);
		if (v < 0)
			return '0;
		if (v > int'(DIST_MAX))
			return DIST_MAX;
		return DIST_W'(v);
	endfunction

	function automatic logic [DIST_W-1:0] any_distance();
		return DIST_W'($urandom_range(int'(DIST_MAX)));
	endfunction

	function automatic trig_cfg_t phase_settings(input int p);
		trig_cfg_t s;
		s.window_ms    = WINDOW_W'($urandom_range(10));
		s.gain         = ($urandom_range(3) == 0) ? GAIN_W'($urandom_range(255))
			: GAIN_W'($urandom_range(3));
		s.offset       = GAIN_W'($urandom_range(255));
		s.enabled      = ($urandom_range(7) != 0);
		s.holdoff_ms   = HOLDOFF_W'($urandom_range(12));
		s.keepalive_ms = SINCE_W'($urandom_range(50));
		// one phase each pushes a setting to its extreme
		case (p)
			0: begin s.gain = '1; s.offset = '1; end
			1: begin s.window_ms = '1; s.holdoff_ms = '1; end
			2: begin s.keepalive_ms = '0; s.holdoff_ms = '0; end
			3: s.enabled = 1'b0;
			4: s.keepalive_ms = SINCE_MAX;
			5: begin s.window_ms = '0; s.gain = '0; s.offset = '0; end
			default: ;
		endcase
		return s;
	endfunction

	// well formed run: start a window, feed samples around a base distance,
	// tick the window out, then watch with samples near the thresholds
	task automatic queue_calibration_run(input trig_cfg_t s);
		int base_a, base_b, jit, samples_left, ticks_left, n, i;
		push_reading(KIND_CALIBRATE, any_distance(), any_distance());
		base_a = ($urandom_range(9) == 0) ? $urandom_range(int'(DIST_MAX))
			: $urandom_range(int'(DIST_MAX) - 64, 600);
		base_b = ($urandom_range(9) == 0) ? $urandom_range(int'(DIST_MAX))
			: $urandom_range(int'(DIST_MAX) - 64, 600);
		// a wide jitter usually drives a threshold negative
		jit = ($urandom_range(9) == 0) ? $urandom_range(2000) : $urandom_range(3);
		samples_left = ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1);
		// an overlong window is only ticked into, never out of
		ticks_left = (s.window_ms <= 64) ? int'(s.window_ms) + 1 : $urandom_range(20);
		while (samples_left > 0 || ticks_left > 0) begin
			if (samples_left > 0 && (ticks_left <= 1 || $urandom_range(1) == 0)) begin
				push_reading(KIND_SAMPLE, clip_distance(base_a + $urandom_range(jit)),
					clip_distance(base_b + $urandom_range(jit)));
				samples_left--;
			end else begin
				push_reading(KIND_TICK, any_distance(), any_distance());
				ticks_left--;
			end
		end
		n = $urandom_range(30, 8);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(99) < 45) begin
				push_reading(KIND_TICK, any_distance(), any_distance());
			end else begin
				case ($urandom_range(5))
					0: push_reading(KIND_SAMPLE, any_distance(), any_distance());
					1: push_reading(KIND_SAMPLE, DIST_MAX, '0);
					default: push_reading(KIND_SAMPLE,
						clip_distance(base_a + $urandom_range(800) - 700),
						clip_distance(base_b + $urandom_range(800) - 700));
				endcase
			end
		end
	endtask

	task automatic queue_noise();
		int n, i;
		logic [1:0] kind;
		n = $urandom_range(10, 3);
		for (i = 0; i < n; i++) begin
			kind = ($urandom_range(99) < 3) ? KIND_UNUSED : 2'($urandom_range(2));
			push_reading(kind, any_distance(), any_distance());
		end
	endtask

	initial begin
		trig_cfg_t s;
		int p, base_count;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// first flow-control mix: sender idles little, receiver a lot
		send_idle_pct = 16;
		recv_idle_pct = 53;

		// directed: short window, threshold is min minus spread, keepalive 3
		s.window_ms = 16'd2; s.gain = 8'd1; s.offset = 8'd0; s.enabled = 1'b1;
		s.holdoff_ms = 16'd0; s.keepalive_ms = 22'd3;
		program_trigger(s);
		// window runs out with no samples and restarts
		push_reading(KIND_TICK, '0, '0);
		push_reading(KIND_TICK, DIST_MAX, DIST_MAX);
		push_reading(KIND_TICK, '0, '0);
		// full-range spread makes the thresholds negative, window restarts
		push_reading(KIND_SAMPLE, DIST_MAX, DIST_MAX);
		push_reading(KIND_SAMPLE, '0, '0);
		push_reading(KIND_UNUSED, DIST_MAX, DIST_MAX);
		push_reading(KIND_TICK, '0, '0);
		push_reading(KIND_TICK, '0, '0);
		push_reading(KIND_TICK, '0, '0);
		// start request in the middle of a running window
		push_reading(KIND_TICK, '0, '0);
		push_reading(KIND_CALIBRATE, DIST_MAX, '0);
		push_reading(KIND_SAMPLE, 15'd20000, 15'd10000);
		push_reading(KIND_SAMPLE, 15'd20004, 15'd10002);
		push_reading(KIND_TICK, '0, '0);
		push_reading(KIND_TICK, '0, '0);
		// valid calibration, and the keepalive held back by the window fires now
		push_reading(KIND_TICK, '0, '0);
		// exactly at threshold a, just above both, then below threshold b
		push_reading(KIND_SAMPLE, 15'd19996, DIST_MAX);
		push_reading(KIND_SAMPLE, 15'd19997, 15'd9999);
		push_reading(KIND_SAMPLE, DIST_MAX, '0);
		wait_settled();

		// directed: zero-length window, maximum gain and offset, flashes off,
		// keepalive at its never-firing value
		s.window_ms = 16'd0; s.gain = '1; s.offset = '1; s.enabled = 1'b0;
		s.holdoff_ms = '1; s.keepalive_ms = SINCE_MAX;
		program_trigger(s);
		push_reading(KIND_CALIBRATE, '0, '0);
		push_reading(KIND_SAMPLE, DIST_MAX, DIST_MAX);
		push_reading(KIND_TICK, '0, '0);
		push_reading(KIND_SAMPLE, '0, '0);
		push_reading(KIND_TICK, '0, '0);
		wait_settled();

		// random phases, three per flow-control mix
		base_count = readings_queued - unused_queued;
		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p / 3)
				0: begin send_idle_pct = 16; recv_idle_pct = 53; end
				1: begin send_idle_pct = 53; recv_idle_pct = 16; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			s = phase_settings(p);
			program_trigger(s);
			while (readings_queued - unused_queued - base_count < (p + 1) * PHASE_READINGS) begin
				if ($urandom_range(99) < 85)
					queue_calibration_run(s);
				else
					queue_noise();
			end
			wait_settled();
		end

		repeat (10) @(posedge clk);
		if (results_due.size() != 0)
			report_mismatch("results never delivered", '0, 64'(results_due.size()));
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ----- calibrated_proximity_trigger_unit.f -----
hdl/cpt_pkg.sv
hdl/cpt_threshold.sv
hdl/calibrated_proximity_trigger_unit.sv
hdl/cpt_checker.sv
dv/calibrated_proximity_trigger_unit_tb.sv
